[hw/rtl/clsr_pkg.sv]
package clsr_pkg;

   // Generator constants. Each modulus sits just below 2**31, so a product is
   // folded as hi * (2**31 - modulus) + lo before one final correction.
   localparam logic [30:0] MOD_A       = 31'd2147483563;
   localparam logic [30:0] MOD_B       = 31'd2147483399;
   localparam logic [15:0] MUL_A       = 16'd40014;
   localparam logic [15:0] MUL_B       = 16'd40692;
   localparam logic [7:0]  FOLD_A      = 8'd85;
   localparam logic [7:0]  FOLD_B      = 8'd249;
   localparam logic [30:0] TOP_OUT     = 31'd2147483562;
   localparam logic [30:0] GEN_A_RESET = 31'd1;
   localparam logic [30:0] GEN_B_RESET = 31'd123456789;

   localparam int DEFAULT_TABLE_DEPTH = 32;
   localparam int WARMUP_STEPS        = 8;

   localparam int PROD_W = 47;

   localparam logic OP_DRAW = 1'b0;
   localparam logic OP_LOAD = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT_MUL,
      ST_INIT_RED,
      ST_IDX_MUL,
      ST_IDX_EST,
      ST_IDX_FIX,
      ST_MUL_A,
      ST_RED_A,
      ST_MUL_B,
      ST_RED_B,
      ST_FINISH
   } state_type;

endpackage

[hw/rtl/clsr_ram.sv]
module clsr_ram #(
   parameter int WIDTH = 31,
   parameter int DEPTH = 32,
   parameter int AW    = 5
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/combined_lcg_shuffle_rng_core.sv]
// Combined two-generator multiplicative congruential random number generator
// with a Bays-Durham shuffle table. Each request transaction asks for exactly
// one draw and yields exactly one response transaction carrying a deviate in
// 1..2147483562 (divide by 2147483563 for a fraction). With req_operation set,
// a positive req_seed_value is loaded into the first generator before the draw;
// a zero or negative seed reseeds both generators from its magnitude (zero as 1) and runs
// TABLE_DEPTH+8 warm-up steps that refill the shuffle table. A single 31x16
// multiplier and one fold-and-correct reduction stage are shared by both
// generators, each modular step a multiply state followed by a reduce state,
// and the same multiplier also turns the previous output into a table index.
// A plain draw runs three index states (a multiply by a 16-bit reciprocal of
// the bucket width, a multiply of that estimate back by the bucket width, and
// one compare that corrects the estimate by at most one), the two states of
// each generator step, and a final state that combines, writes the table back
// and loads the response register; the block is idle again from that edge.
// A reseeding draw runs the warm-up steps before the index states. The block
// takes one transaction at a time; a finished response waits in its output
// register while the next request is already accepted, and the final state of
// a draw waits for as long as an earlier response is still held by rsp_stall.
module combined_lcg_shuffle_rng_core
   import clsr_pkg::*;
#(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_operation,
   input  logic signed [31:0] req_seed_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [30:0]        rsp_deviate
);

   // Table index width and init step counter width.
   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + WARMUP_STEPS);

   // Width of one index bucket and its 16-bit reciprocal. The reciprocal is
   // scaled so the estimated quotient is never above the true one and at most
   // one below it.
   localparam longint BUCKET_L = 64'd1 + 64'(TOP_OUT) / TABLE_DEPTH;
   localparam int REC_SHIFT = $clog2(BUCKET_L) + 15;
   localparam logic [15:0] RECIP = 16'((64'd1 << REC_SHIFT) / BUCKET_L);
   localparam logic [30:0] BUCKET_C = 31'(BUCKET_L);
   localparam logic [IW-1:0] IDX_MAX = IW'(TABLE_DEPTH - 1);
   localparam logic [CW-1:0] INIT_STEPS = CW'(TABLE_DEPTH + WARMUP_STEPS - 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

   state_type state_ff, state_in;

   // Architectural generator state.
   logic [30:0] first_ff, first_in;
   logic [30:0] second_ff, second_in;
   logic [30:0] last_ff, last_in;

   // Shared modular multiplier: registered product, then fold and correct.
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [15:0]       mul_coef;
   logic [30:0]       mul_opnd;
   logic [15:0]       prod_hi;
   logic [30:0]       prod_lo;
   logic [7:0]        fold_coef;
   logic [30:0]       red_mod;
   logic [31:0]       fold_sum;
   logic [30:0]       red_out;

   // Warm-up step counter.
   logic [CW-1:0] cnt_ff, cnt_in;

   // Table index from the previous output.
   logic [IW-1:0] q_est;
   logic [IW-1:0] q_ff, q_in;
   logic [IW-1:0] idx;

   // Entries never written since reset read as zero.
   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic                   ent_valid_ff, ent_valid_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [30:0] deviate_ff, deviate_in;

   // Table memory port signals.
   logic          ram_we;
   logic [IW-1:0] ram_waddr;
   logic [30:0]   ram_wdata;
   logic          ram_re;
   logic [30:0]   ram_rdata;

   // Seed decode.
   logic [31:0] seed_neg;
   logic [30:0] seed_mag;

   // Draw combination.
   logic [30:0] entry;
   logic [31:0] diff;
   logic [30:0] draw_out;

   clsr_ram #(
      .WIDTH(31),
      .DEPTH(TABLE_DEPTH),
      .AW   (IW)
   ) u_table (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_en  (ram_re),
      .rd_addr(idx),
      .rd_data(ram_rdata)
   );

   // The estimated index is the scaled product of the previous output and the
   // reciprocal.
   assign q_est = prod_ff[REC_SHIFT +: IW];

   // The index states use the multiplier first for the reciprocal product and
   // then to multiply the estimate back by the bucket width. The second
   // generator is only stepped in its own two states; everything else
   // (warm-up and the draw) steps the first generator.
   always_comb begin
      case (state_ff)
         ST_IDX_MUL: begin
            mul_coef = RECIP;
            mul_opnd = last_ff;
         end
         ST_IDX_EST: begin
            mul_coef = 16'(q_est);
            mul_opnd = BUCKET_C;
         end
         ST_MUL_B: begin
            mul_coef = MUL_B;
            mul_opnd = second_ff;
         end
         default: begin
            mul_coef = MUL_A;
            mul_opnd = first_ff;
         end
      endcase
   end

   assign fold_coef = (state_ff == ST_RED_B) ? FOLD_B : FOLD_A;
   assign red_mod   = (state_ff == ST_RED_B) ? MOD_B : MOD_A;

   // The product is below 2**47, so hi*fold + lo stays below twice the modulus
   // and a single conditional subtract finishes the reduction.
   assign prod_hi  = prod_ff[PROD_W-1:31];
   assign prod_lo  = prod_ff[30:0];
   assign fold_sum = {1'b0, prod_lo} + 32'(24'(prod_hi) * 24'(fold_coef));
   assign red_out  = (fold_sum >= {1'b0, red_mod}) ? 31'(fold_sum - {1'b0, red_mod})
                                                   : fold_sum[30:0];

   // The quotient never exceeds the last entry; the clamp is only a guard.
   assign idx = (q_ff > IDX_MAX) ? IDX_MAX : q_ff;

   // Magnitude of a non-positive seed, saturating the most negative value.
   assign seed_neg = ~req_seed_value + 32'd1;
   always_comb begin
      if (req_seed_value == 32'sd0) begin
         seed_mag = 31'd1;
      end else if (seed_neg[31]) begin
         seed_mag = 31'h7FFF_FFFF;
      end else begin
         seed_mag = seed_neg[30:0];
      end
   end

   // New deviate: selected entry minus the second generator, wrapped upward
   // when the difference is zero or negative.
   assign entry    = ent_valid_ff ? ram_rdata : '0;
   assign diff     = {1'b0, entry} - {1'b0, second_ff};
   assign draw_out = (diff[31] || (diff == 32'd0)) ? 31'(diff + {1'b0, TOP_OUT})
                                                   : diff[30:0];

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_deviate = deviate_ff;

   always_comb begin
      state_in     = state_ff;
      first_in     = first_ff;
      second_in    = second_ff;
      last_in      = last_ff;
      prod_in      = PROD_W'(mul_coef) * PROD_W'(mul_opnd);
      cnt_in       = cnt_ff;
      q_in         = q_ff;
      valid_in     = valid_ff;
      ent_valid_in = ent_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      deviate_in   = deviate_ff;
      ram_we       = 1'b0;
      ram_waddr    = idx;
      ram_wdata    = first_ff;
      ram_re       = 1'b0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_IDX_MUL;
               if (req_operation == OP_LOAD) begin
                  if (req_seed_value > 32'sd0) begin
                     first_in = req_seed_value[30:0];
                  end else begin
                     first_in  = seed_mag;
                     second_in = seed_mag;
                     cnt_in    = INIT_STEPS;
                     state_in  = ST_INIT_MUL;
                  end
               end
            end
         end
         ST_INIT_MUL: begin
            state_in = ST_INIT_RED;
         end
         ST_INIT_RED: begin
            first_in = red_out;
            if (cnt_ff < DEPTH_C) begin
               ram_we              = 1'b1;
               ram_waddr           = cnt_ff[IW-1:0];
               ram_wdata           = red_out;
               valid_in[ram_waddr] = 1'b1;
            end
            if (cnt_ff == '0) begin
               last_in  = red_out;
               state_in = ST_IDX_MUL;
            end else begin
               cnt_in   = cnt_ff - CW'(1);
               state_in = ST_INIT_MUL;
            end
         end
         ST_IDX_MUL: begin
            state_in = ST_IDX_EST;
         end
         ST_IDX_EST: begin
            q_in     = q_est;
            state_in = ST_IDX_FIX;
         end
         ST_IDX_FIX: begin
            // The estimate is low by one when a whole bucket still remains.
            if ((last_ff - prod_ff[30:0]) >= BUCKET_C) begin
               q_in = q_ff + IW'(1);
            end
            state_in = ST_MUL_A;
         end
         ST_MUL_A: begin
            ram_re       = 1'b1;
            ent_valid_in = valid_ff[idx];
            state_in     = ST_RED_A;
         end
         ST_RED_A: begin
            first_in = red_out;
            state_in = ST_MUL_B;
         end
         ST_MUL_B: begin
            state_in = ST_RED_B;
         end
         ST_RED_B: begin
            second_in = red_out;
            state_in  = ST_FINISH;
         end
         ST_FINISH: begin
            // Wait here only while the previous response is still held.
            if (!(rsp_valid_ff && rsp_stall)) begin
               deviate_in    = draw_out;
               rsp_valid_in  = 1'b1;
               last_in       = draw_out;
               ram_we        = 1'b1;
               ram_waddr     = idx;
               ram_wdata     = first_ff;
               valid_in[idx] = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         first_ff     <= GEN_A_RESET;
         second_ff    <= GEN_B_RESET;
         last_ff      <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         first_ff     <= first_in;
         second_ff    <= second_in;
         last_ff      <= last_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff      <= prod_in;
      cnt_ff       <= cnt_in;
      q_ff         <= q_in;
      ent_valid_ff <= ent_valid_in;
      deviate_ff   <= deviate_in;
   end

`ifndef SYNTHESIS
   // A delivered deviate always lies in 1..2147483562.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_deviate != 31'd0) && (rsp_deviate <= TOP_OUT))
      else $error("deviate out of range");

   // Each reduction leaves the stepped generator below its modulus.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RED_A) |=> (first_ff < MOD_A))
      else $error("first generator not reduced");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RED_B) |=> (second_ff < MOD_B))
      else $error("second generator not reduced");

   // The corrected quotient never needs the clamp.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL_A) |-> (q_ff <= IDX_MAX))
      else $error("table index beyond depth");

   // Finishing with a free output register posts the response and frees the input.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) && !(rsp_valid_ff && rsp_stall)
         |=> rsp_valid_ff && (state_ff == ST_IDLE))
      else $error("draw finished without a response");
`endif

endmodule
